@@ design/pac_pkg.sv @@
// shared types and constants for the polygon area and centroid core
`timescale 1ns / 1ps
package pac_pkg;

    localparam int COORD_W      = 16;
    localparam int AREA_W       = 40;
    localparam int CROSS_W      = 43;
    localparam int WEIGHT_W     = 60;
    localparam int PROD_W       = 2 * COORD_W;
    localparam int EDGE_A_W     = PROD_W + 1;
    localparam int SUM2_W       = COORD_W + 1;
    localparam int WPROD_W      = SUM2_W + EDGE_A_W;
    localparam int DIVISOR_W    = CROSS_W + 2;
    localparam int QUOT_W       = COORD_W;
    localparam int MAX_VERTICES_DEF = 1024;
    localparam int QUEUE_DEPTH  = 4;

    typedef struct packed {
        logic signed [COORD_W-1:0] vertex_x;
        logic signed [COORD_W-1:0] vertex_y;
        logic                      last_vertex;
    } vertex_t;

    typedef struct packed {
        logic        [AREA_W-1:0]  area;
        logic signed [COORD_W-1:0] centroid_x;
        logic signed [COORD_W-1:0] centroid_y;
        logic                      degenerate;
    } result_t;

    // one edge of the ring, finish marks the closing edge of a polygon
    typedef struct packed {
        logic signed [COORD_W-1:0] x0;
        logic signed [COORD_W-1:0] y0;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic                      finish;
    } edge_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

@@ design/pac_front.sv @@
// front end: takes vertices and turns them into ring edges
`timescale 1ns / 1ps
module pac_front #(
    parameter int MAX_VERTICES = pac_pkg::MAX_VERTICES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  vertex_valid,
    output logic                  vertex_stall,
    input  pac_pkg::vertex_t      vertex,
    input  pac_pkg::queue_status_t q_status,
    output logic                  push,
    output pac_pkg::edge_t        push_edge
);
    import pac_pkg::*;

    localparam int CNT_W = $clog2(MAX_VERTICES + 1);

    logic signed [COORD_W-1:0] first_x_reg, first_y_reg, prev_x_reg, prev_y_reg;
    logic signed [COORD_W-1:0] first_x_next, first_y_next, prev_x_next, prev_y_next;
    logic                      in_poly_reg, in_poly_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    edge_t                     pend_reg, pend_next;
    logic                      pend_valid_reg, pend_valid_next;
    logic                      accept;

    assign vertex_stall = pend_valid_reg || q_status.full;
    assign accept       = vertex_valid && !vertex_stall;

    always_comb
    begin
        first_x_next    = first_x_reg;
        first_y_next    = first_y_reg;
        prev_x_next     = prev_x_reg;
        prev_y_next     = prev_y_reg;
        in_poly_next    = in_poly_reg;
        count_next      = count_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        push            = 1'b0;
        push_edge       = pend_reg;
        if (pend_valid_reg)
        begin
            if (!q_status.full)
            begin
                push            = 1'b1;
                pend_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            priority if (!in_poly_reg)
            begin
                first_x_next = vertex.vertex_x;
                first_y_next = vertex.vertex_y;
                prev_x_next  = vertex.vertex_x;
                prev_y_next  = vertex.vertex_y;
                count_next   = CNT_W'(1);
                in_poly_next = !vertex.last_vertex;
                push         = vertex.last_vertex;
                push_edge    = '{vertex.vertex_x, vertex.vertex_y,
                                 vertex.vertex_x, vertex.vertex_y, 1'b1};
            end
            else if (count_reg < CNT_W'(MAX_VERTICES))
            begin
                push        = 1'b1;
                push_edge   = '{prev_x_reg, prev_y_reg,
                                vertex.vertex_x, vertex.vertex_y, 1'b0};
                prev_x_next = vertex.vertex_x;
                prev_y_next = vertex.vertex_y;
                count_next  = count_reg + CNT_W'(1);
                if (vertex.last_vertex)
                begin
                    pend_next       = '{vertex.vertex_x, vertex.vertex_y,
                                        first_x_reg, first_y_reg, 1'b1};
                    pend_valid_next = 1'b1;
                    in_poly_next    = 1'b0;
                end
            end
            else
            begin
                // vertex past the limit is dropped, a last flag still closes
                push         = vertex.last_vertex;
                push_edge    = '{prev_x_reg, prev_y_reg, first_x_reg, first_y_reg, 1'b1};
                in_poly_next = !vertex.last_vertex;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_poly_reg    <= 1'b0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            first_x_reg    <= '0;
            first_y_reg    <= '0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
        end
        else
        begin
            in_poly_reg    <= in_poly_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            first_x_reg    <= first_x_next;
            first_y_reg    <= first_y_next;
            prev_x_reg     <= prev_x_next;
            prev_y_reg     <= prev_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
    end

endmodule

@@ design/pac_queue.sv @@
// short edge queue between front and back
`timescale 1ns / 1ps
module pac_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  pac_pkg::edge_t         push_edge,
    input  logic                   pop,
    output pac_pkg::edge_t         head,
    output pac_pkg::queue_status_t status
);
    import pac_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    edge_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]    fill_reg;

    assign head         = mem_reg[rd_ptr_reg];
    assign status.full  = (fill_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign status.empty = (fill_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            fill_reg <= fill_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_edge;
    end

endmodule

@@ design/pac_back.sv @@
// back end: edge products, shoelace sums, centroid division, result register
`timescale 1ns / 1ps
module pac_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pac_pkg::queue_status_t q_status,
    input  pac_pkg::edge_t         head,
    output logic                   pop,
    output logic                   result_valid,
    input  logic                   result_stall,
    output pac_pkg::result_t       result
);
    import pac_pkg::*;

    localparam int REM_W = WEIGHT_W;
    localparam int DSH_W = WEIGHT_W + 1;
    localparam int STEP_W = $clog2(QUOT_W);

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_DIFF, S_WEIGHT, S_ACC, S_DSETUP, S_DIV, S_OUT
    } state_t;

    state_t                     state_reg;
    edge_t                      edge_reg;
    logic signed [PROD_W-1:0]   p1_reg, p2_reg;
    logic signed [EDGE_A_W-1:0] a_reg;
    logic signed [SUM2_W-1:0]   sx_reg, sy_reg;
    logic signed [WPROD_W-1:0]  wx_reg, wy_reg;
    logic signed [CROSS_W-1:0]  cross_reg;
    logic signed [WEIGHT_W-1:0] wsum_reg [2];
    logic [REM_W-1:0]           rem_reg [2];
    logic [DSH_W-1:0]           dsh_reg [2];
    logic [QUOT_W-1:0]          q_reg [2];
    logic                       neg_reg [2];
    logic                       ovf_reg [2];
    logic [STEP_W-1:0]          step_reg;
    logic                       out_valid_reg;
    result_t                    out_reg;

    logic signed [DIVISOR_W-1:0] div_s;
    logic [DIVISOR_W-1:0]        div_mag;
    logic [CROSS_W-1:0]          cross_mag;
    logic [REM_W-1:0]            w_mag [2];
    logic [REM_W-1:0]            rem_next [2];
    logic [QUOT_W-1:0]           q_next [2];
    logic signed [COORD_W-1:0]   cent [2];
    logic [AREA_W-1:0]           area_val;
    logic                        out_free;

    assign pop          = (state_reg == S_IDLE) && !q_status.empty;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;
    assign out_free     = !out_valid_reg || !result_stall;

    assign div_s     = (DIVISOR_W'(cross_reg) <<< 1) + DIVISOR_W'(cross_reg);
    assign div_mag   = div_s[DIVISOR_W-1] ? DIVISOR_W'(-div_s) : DIVISOR_W'(div_s);
    assign cross_mag = cross_reg[CROSS_W-1] ? CROSS_W'(-cross_reg) : CROSS_W'(cross_reg);
    // half the magnitude, saturated to the area range
    assign area_val  = (cross_mag[CROSS_W-1:AREA_W+1] != '0) ? '1
                                                            : cross_mag[AREA_W:1];

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            w_mag[i] = wsum_reg[i][WEIGHT_W-1] ? REM_W'(-wsum_reg[i])
                                                : REM_W'(wsum_reg[i]);
            // one restoring step per cycle
            if ({1'b0, rem_reg[i]} >= dsh_reg[i])
            begin
                rem_next[i] = rem_reg[i] - REM_W'(dsh_reg[i]);
                q_next[i]   = {q_reg[i][QUOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[i] = rem_reg[i];
                q_next[i]   = {q_reg[i][QUOT_W-2:0], 1'b0};
            end
            // sign and saturation of the quotient magnitude
            priority if (ovf_reg[i])
                cent[i] = neg_reg[i] ? {1'b1, {(COORD_W-1){1'b0}}}
                                     : {1'b0, {(COORD_W-1){1'b1}}};
            else if (neg_reg[i])
                cent[i] = (q_reg[i] > {1'b1, {(QUOT_W-1){1'b0}}})
                          ? {1'b1, {(COORD_W-1){1'b0}}} : COORD_W'(-q_reg[i]);
            else
                cent[i] = q_reg[i][QUOT_W-1] ? {1'b0, {(COORD_W-1){1'b1}}}
                                             : COORD_W'(q_reg[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            cross_reg     <= '0;
            wsum_reg[0]   <= '0;
            wsum_reg[1]   <= '0;
            step_reg      <= '0;
        end
        else
        begin
            // set when a result loads, held while the receiver stalls
            out_valid_reg <= (state_reg == S_OUT && out_free)
                             || (out_valid_reg && result_stall);
            unique case (state_reg)
                S_IDLE:
                begin
                    if (!q_status.empty)
                        state_reg <= S_MUL;
                end
                S_MUL:    state_reg <= S_DIFF;
                S_DIFF:   state_reg <= S_WEIGHT;
                S_WEIGHT: state_reg <= S_ACC;
                S_ACC:
                begin
                    cross_reg   <= cross_reg + CROSS_W'(a_reg);
                    wsum_reg[0] <= wsum_reg[0] + WEIGHT_W'(wx_reg);
                    wsum_reg[1] <= wsum_reg[1] + WEIGHT_W'(wy_reg);
                    state_reg   <= edge_reg.finish ? S_DSETUP : S_IDLE;
                end
                S_DSETUP:
                begin
                    step_reg  <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(QUOT_W - 1))
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        cross_reg     <= '0;
                        wsum_reg[0]   <= '0;
                        wsum_reg[1]   <= '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            edge_reg <= head;
        p1_reg <= edge_reg.x0 * edge_reg.y1;
        p2_reg <= edge_reg.x1 * edge_reg.y0;
        a_reg  <= EDGE_A_W'(p1_reg) - EDGE_A_W'(p2_reg);
        sx_reg <= SUM2_W'(edge_reg.x0) + SUM2_W'(edge_reg.x1);
        sy_reg <= SUM2_W'(edge_reg.y0) + SUM2_W'(edge_reg.y1);
        wx_reg <= WPROD_W'(sx_reg) * WPROD_W'(a_reg);
        wy_reg <= WPROD_W'(sy_reg) * WPROD_W'(a_reg);
        for (int i = 0; i < 2; i++)
        begin
            if (state_reg == S_DSETUP)
            begin
                rem_reg[i] <= w_mag[i];
                dsh_reg[i] <= DSH_W'({div_mag, {(QUOT_W-1){1'b0}}});
                q_reg[i]   <= '0;
                neg_reg[i] <= wsum_reg[i][WEIGHT_W-1] ^ div_s[DIVISOR_W-1];
                ovf_reg[i] <= {1'b0, w_mag[i]} >= DSH_W'({div_mag, {QUOT_W{1'b0}}});
            end
            else if (state_reg == S_DIV)
            begin
                rem_reg[i] <= rem_next[i];
                q_reg[i]   <= q_next[i];
                dsh_reg[i] <= dsh_reg[i] >> 1;
            end
        end
        if (state_reg == S_OUT && out_free)
        begin
            if (cross_reg == '0)
                out_reg <= '{'0, '0, '0, 1'b1};
            else
                out_reg <= '{area_val, cent[0], cent[1], 1'b0};
        end
    end

endmodule

@@ design/polygon_area_centroid_core.sv @@
// top level of the polygon area and centroid core
`timescale 1ns / 1ps
// Streams polygon vertices (signed Q12.4, last_vertex on the final one) and
// returns one result per polygon: the absolute shoelace area with 8
// fractional bits, saturated to 40 bits, and the centroid in Q12.4,
// truncated toward zero and saturated; a zero signed area gives the
// degenerate flag with area and centroid zero. Vertices past MAX_VERTICES in
// one polygon are dropped, and the sums are exact up to 1024 vertices.
// Timing: the front takes one vertex per cycle while the four-entry edge
// queue has room and no closing edge is pending; the back pops an edge
// only from idle and works through it (pop, cross products, difference,
// weight products, accumulate) before it takes the next. The last vertex
// adds the closing edge, then a setup state, 16 restoring division steps
// and an output state; the result register lets the next polygon's edges
// proceed while a result waits to be taken.
module polygon_area_centroid_core #(
    parameter int MAX_VERTICES = pac_pkg::MAX_VERTICES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             vertex_valid,
    output logic             vertex_stall,
    input  pac_pkg::vertex_t vertex,
    output logic             result_valid,
    input  logic             result_stall,
    output pac_pkg::result_t result
);
    import pac_pkg::*;

    // edge transfer from front into queue
    logic          push;
    edge_t         push_edge;
    // queue head to back
    logic          pop;
    edge_t         head;
    queue_status_t q_status;

    // front: ring bookkeeping, first and previous vertex, vertex count
    pac_front #(
        .MAX_VERTICES(MAX_VERTICES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .vertex_valid (vertex_valid),
        .vertex_stall (vertex_stall),
        .vertex       (vertex),
        .q_status     (q_status),
        .push         (push),
        .push_edge    (push_edge)
    );

    // decouples vertex intake from edge arithmetic
    pac_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_edge (push_edge),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    // back: products, sums, division, result register
    pac_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

@@ design/pac_checker.sv @@
// port-level checks for the polygon area and centroid core, with bind
`timescale 1ns / 1ps
module pac_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             vertex_valid,
    input logic             vertex_stall,
    input pac_pkg::vertex_t vertex,
    input logic             result_valid,
    input logic             result_stall,
    input pac_pkg::result_t result
);
    import pac_pkg::*;

    logic [7:0] open_reg;
    logic       last_xfer;
    logic       res_xfer;

    assign last_xfer = vertex_valid && !vertex_stall && vertex.last_vertex;
    assign res_xfer  = result_valid && !result_stall;

    // closed polygons whose result is not yet out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            open_reg <= '0;
        else
            open_reg <= open_reg + 8'(last_xfer) - 8'(res_xfer);
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.degenerate |->
            result.area == '0 && result.centroid_x == '0 && result.centroid_y == '0)
        else $error("degenerate result carries nonzero fields");

    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        res_xfer |-> open_reg != '0)
        else $error("result without a closed polygon");

endmodule

bind polygon_area_centroid_core pac_checker u_pac_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .vertex_valid (vertex_valid),
    .vertex_stall (vertex_stall),
    .vertex       (vertex),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
